@@ src/kot_pkg.sv @@
`default_nettype none
package kot_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF = 32;
  localparam int ID_W = 32;
  localparam int CNT_W = 7;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_ERASE = 3'd1;
  localparam logic [2:0] REQ_SET_OUTLIER = 3'd2;
  localparam logic [2:0] REQ_CONTAINS = 3'd3;
  localparam logic [2:0] REQ_BY_KEYFRAME = 3'd4;
  localparam logic [2:0] REQ_BY_MAP_POINT = 3'd5;
  localparam logic [2:0] REQ_LIST_ALL = 3'd6;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic bad_record;
    logic [ID_W-1:0] kf_id;
    logic [ID_W-1:0] mp_id;
    logic [31:0] pixel_x_bits;
    logic [31:0] pixel_y_bits;
    logic [7:0] octave;
    logic outlier_flag;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic match_valid;
    logic [ID_W-1:0] kf_id;
    logic [ID_W-1:0] mp_id;
    logic [31:0] pixel_x_bits;
    logic [31:0] pixel_y_bits;
    logic [7:0] octave;
    logic outlier;
    logic last;
    logic [CNT_W-1:0] entry_count;
  } res_t;
endpackage
`default_nettype wire

@@ src/keyed_observation_table.sv @@
// Each request walks the stored entries in the record memory, one entry per read/check pair,
// then emits its result words; erase also shifts each later entry down one place.
// The back end takes one request at a time and does not accept the next until the last result word
// of the current one is queued; a full result queue stalls it.
// A two-word command queue and a two-word result queue decouple both sides.
// Reset (rst, synchronous, active high) empties both queues and the table.
`default_nettype none
module keyed_observation_table #(
  parameter int CAPACITY = kot_pkg::CAPACITY_DEF,
  parameter int ID_BITS = kot_pkg::ID_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic [2:0] req_type,
  input wire logic [31:0] kf_id,
  input wire logic [31:0] mp_id,
  input wire logic [31:0] pixel_x_bits,
  input wire logic [31:0] pixel_y_bits,
  input wire logic signed [7:0] octave,
  input wire logic outlier_flag,
  output logic empty,
  input wire logic pop,
  output logic [2:0] status,
  output logic match_valid,
  output logic [31:0] out_keyframe_id,
  output logic [31:0] out_map_point_id,
  output logic [31:0] out_pixel_x_bits,
  output logic [31:0] out_pixel_y_bits,
  output logic signed [7:0] out_octave,
  output logic out_outlier,
  output logic last,
  output logic [6:0] entry_count
);
  kot_pkg::cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  kot_pkg::res_t res;
  logic res_valid;

  kot_front #(.ID_BITS(ID_BITS)) u_front (
    .clk, .rst, .push, .full, .req_type, .kf_id, .mp_id,
    .pixel_x_bits, .pixel_y_bits, .octave, .outlier_flag,
    .cmd, .cmd_valid, .cmd_take
  );

  kot_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .res, .res_valid, .res_take(pop)
  );

  assign empty = !res_valid;
  assign status = res.status;
  assign match_valid = res.match_valid;
  assign out_keyframe_id = res.kf_id;
  assign out_map_point_id = res.mp_id;
  assign out_pixel_x_bits = res.pixel_x_bits;
  assign out_pixel_y_bits = res.pixel_y_bits;
  assign out_octave = res.octave;
  assign out_outlier = res.outlier;
  assign last = res.last;
  assign entry_count = res.entry_count;
endmodule
`default_nettype wire

@@ src/kot_front.sv @@
`default_nettype none
module kot_front #(
  parameter int ID_BITS = kot_pkg::ID_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic [2:0] req_type,
  input wire logic [31:0] kf_id,
  input wire logic [31:0] mp_id,
  input wire logic [31:0] pixel_x_bits,
  input wire logic [31:0] pixel_y_bits,
  input wire logic signed [7:0] octave,
  input wire logic outlier_flag,
  output kot_pkg::cmd_t cmd,
  output logic cmd_valid,
  input wire logic cmd_take
);
  localparam int DEPTH = 2;
  kot_pkg::cmd_t q [DEPTH];
  logic [1:0] cnt;
  logic rd_ptr;
  logic wr_ptr;
  logic [31:0] id_mask;
  kot_pkg::cmd_t c;
  logic do_push;
  logic do_pop;

  assign id_mask = (ID_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ID_BITS) - 32'd1);
  assign full = (cnt == 2'(DEPTH));
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  always_comb begin
    c.req_type = req_type;
    c.bad_record = (pixel_x_bits[30:23] == 8'hFF) || (pixel_y_bits[30:23] == 8'hFF) ||
      octave[7];
    c.kf_id = kf_id & id_mask;
    c.mp_id = mp_id & id_mask;
    c.pixel_x_bits = pixel_x_bits;
    c.pixel_y_bits = pixel_y_bits;
    c.octave = octave;
    c.outlier_flag = outlier_flag;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= c;
    end
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

@@ src/kot_back.sv @@
`default_nettype none
module kot_back #(
  parameter int CAPACITY = kot_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire kot_pkg::cmd_t cmd,
  input wire logic cmd_valid,
  output logic cmd_take,
  output kot_pkg::res_t res,
  output logic res_valid,
  input wire logic res_take
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = kot_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_EMIT}
    state_t;

  typedef struct packed {
    logic [kot_pkg::ID_W-1:0] kf;
    logic [kot_pkg::ID_W-1:0] mp;
    logic [31:0] px;
    logic [31:0] py;
    logic [7:0] oct;
    logic outl;
  } rec_t;

  rec_t mem [CAPACITY];
  rec_t rd_data;
  state_t state;
  kot_pkg::cmd_t cur;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic found;
  logic any_hit;
  logic hit;
  logic [1:0] pend_v;
  kot_pkg::res_t pend [2];
  logic pend_rd;
  logic pend_wr;
  kot_pkg::res_t held;
  kot_pkg::res_t new_res;
  logic new_push;

  assign res_valid = (pend_v != 2'd0);
  assign res = pend[pend_rd];

  always_comb begin
    hit = 1'b0;
    case (cur.req_type)
      kot_pkg::REQ_BY_KEYFRAME: hit = (rd_data.kf == cur.kf_id);
      kot_pkg::REQ_BY_MAP_POINT: hit = (rd_data.mp == cur.mp_id);
      kot_pkg::REQ_LIST_ALL: hit = 1'b1;
      default: hit = (rd_data.kf == cur.kf_id) && (rd_data.mp == cur.mp_id);
    endcase
  end

  function automatic kot_pkg::res_t mk(input logic [2:0] st, input logic mv, input rec_t r,
                                       input logic lst, input logic [CW-1:0] n);
    kot_pkg::res_t o;
    o.status = st;
    o.match_valid = mv;
    o.kf_id = mv ? r.kf : '0;
    o.mp_id = mv ? r.mp : '0;
    o.pixel_x_bits = mv ? r.px : '0;
    o.pixel_y_bits = mv ? r.py : '0;
    o.octave = mv ? r.oct : '0;
    o.outlier = mv ? r.outl : 1'b0;
    o.last = lst;
    o.entry_count = n;
    return o;
  endfunction

  logic scan_req;
  logic space;
  assign scan_req = (cur.req_type == kot_pkg::REQ_BY_KEYFRAME) ||
    (cur.req_type == kot_pkg::REQ_BY_MAP_POINT) || (cur.req_type == kot_pkg::REQ_LIST_ALL);
  assign space = (pend_v != 2'd2);
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  logic mem_we;
  logic [AW-1:0] mem_wa;
  rec_t mem_wd;
  logic [AW-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  always_comb begin
    mem_ra = idx[AW-1:0];
    mem_we = 1'b0;
    mem_wa = idx[AW-1:0];
    mem_wd = rd_data;
    new_push = 1'b0;
    new_res = mk(kot_pkg::ST_OK, 1'b0, rd_data, 1'b1, count);
    case (state)
      S_CHECK: begin
        if (scan_req && hit && any_hit && space) begin
          new_push = 1'b1;
          new_res = held;
        end
        if (cur.req_type == kot_pkg::REQ_SET_OUTLIER && hit) begin
          mem_we = 1'b1;
          mem_wd.outl = cur.outlier_flag;
        end
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx - CW'(1));
      end
      S_EMIT: begin
        if (space) new_push = 1'b1;
        if (cur.req_type == kot_pkg::REQ_ADD) begin
          if (cur.bad_record) begin
            new_res = mk(kot_pkg::ST_INVALID, 1'b0, rd_data, 1'b1, count);
          end else if (found) begin
            new_res = mk(kot_pkg::ST_DUPLICATE, 1'b0, rd_data, 1'b1, count);
          end else if (count >= CW'(CAPACITY)) begin
            new_res = mk(kot_pkg::ST_FULL, 1'b0, rd_data, 1'b1, count);
          end else begin
            new_res = mk(kot_pkg::ST_OK, 1'b0, rd_data, 1'b1, count + CW'(1));
            mem_we = space;
            mem_wa = count[AW-1:0];
            mem_wd.kf = cur.kf_id;
            mem_wd.mp = cur.mp_id;
            mem_wd.px = cur.pixel_x_bits;
            mem_wd.py = cur.pixel_y_bits;
            mem_wd.oct = cur.octave;
            mem_wd.outl = cur.outlier_flag;
          end
        end else if (cur.req_type == kot_pkg::REQ_ERASE) begin
          new_res = mk(found ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, 1'b0, rd_data, 1'b1,
                       found ? count - CW'(1) : count);
        end else if (cur.req_type == kot_pkg::REQ_SET_OUTLIER) begin
          new_res = mk(found ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, 1'b0, rd_data, 1'b1,
                       count);
        end else if (cur.req_type == kot_pkg::REQ_CONTAINS) begin
          new_res = mk(found ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, found, rd_data, 1'b1,
                       count);
        end else if (scan_req) begin
          if (any_hit) begin
            new_res = held;
            new_res.last = 1'b1;
          end else begin
            new_res = mk(kot_pkg::ST_NOT_FOUND, 1'b0, rd_data, 1'b1, count);
          end
        end else begin
          new_res = mk(kot_pkg::ST_INVALID, 1'b0, rd_data, 1'b1, count);
        end
      end
      default: begin
      end
    endcase
  end

  logic pop;
  assign pop = res_take && res_valid;

  always_ff @(posedge clk) begin
    if (new_push) pend[pend_wr] <= new_res;
    if (state == S_IDLE && cmd_valid) cur <= cmd;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      found <= 1'b0;
      any_hit <= 1'b0;
      pend_v <= '0;
      pend_rd <= 1'b0;
      pend_wr <= 1'b0;
    end else begin
      if (new_push) pend_wr <= !pend_wr;
      if (pop) pend_rd <= !pend_rd;
      pend_v <= pend_v + 2'(new_push) - 2'(pop);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            idx <= '0;
            found <= 1'b0;
            any_hit <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (idx >= count) begin
            state <= S_EMIT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (scan_req) begin
            if (!hit) begin
              idx <= idx + CW'(1);
              state <= S_READ;
            end else if (!any_hit || space) begin
              any_hit <= 1'b1;
              held <= mk(kot_pkg::ST_OK, 1'b1, rd_data, 1'b0, count);
              idx <= idx + CW'(1);
              state <= S_READ;
            end
          end else if (hit) begin
            found <= 1'b1;
            if (cur.req_type == kot_pkg::REQ_ERASE) begin
              idx <= idx + CW'(1);
              state <= S_SHIFT_RD;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_SHIFT_RD: begin
          if (idx >= count) begin
            state <= S_EMIT;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + CW'(1);
          state <= S_SHIFT_RD;
        end
        S_EMIT: begin
          if (space) begin
            if (cur.req_type == kot_pkg::REQ_ADD) begin
              if (!cur.bad_record && !found && count < CW'(CAPACITY)) count <= count + CW'(1);
            end else if (cur.req_type == kot_pkg::REQ_ERASE && found) begin
              count <= count - CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/kot_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module kot_checker #(
  parameter int CAPACITY = kot_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic [2:0] req_type,
  input wire logic [31:0] kf_id,
  input wire logic [31:0] mp_id,
  input wire logic [31:0] pixel_x_bits,
  input wire logic [31:0] pixel_y_bits,
  input wire logic [7:0] octave,
  input wire logic outlier_flag,
  input wire logic empty,
  input wire logic pop,
  input wire logic [2:0] status,
  input wire logic match_valid,
  input wire logic [31:0] out_keyframe_id,
  input wire logic [31:0] out_map_point_id,
  input wire logic [31:0] out_pixel_x_bits,
  input wire logic [31:0] out_pixel_y_bits,
  input wire logic [7:0] out_octave,
  input wire logic out_outlier,
  input wire logic last,
  input wire logic [6:0] entry_count,
  output int fail_count,
  output int pending
);
  typedef struct {
    logic [31:0] kf;
    logic [31:0] mp;
    logic [31:0] px;
    logic [31:0] py;
    logic [7:0] oct;
    logic outl;
  } rec_t;

  rec_t table_q[$];
  kot_pkg::res_t answers[$];

  function automatic int find_key(logic [31:0] kf, logic [31:0] mp);
    foreach (table_q[i]) if (table_q[i].kf == kf && table_q[i].mp == mp) return i;
    return -1;
  endfunction

  function automatic void post(logic [2:0] st, int idx, logic lst);
    kot_pkg::res_t r;
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      r.match_valid = 1'b1;
      r.kf_id = table_q[idx].kf;
      r.mp_id = table_q[idx].mp;
      r.pixel_x_bits = table_q[idx].px;
      r.pixel_y_bits = table_q[idx].py;
      r.octave = table_q[idx].oct;
      r.outlier = table_q[idx].outl;
    end
    r.last = lst;
    r.entry_count = 7'(table_q.size());
    answers.insert(answers.size(), r);
  endfunction

  function automatic void apply_request();
    int idx;
    int hits[$];
    rec_t r;
    idx = find_key(kf_id, mp_id);
    case (req_type)
      kot_pkg::REQ_ADD: begin
        if (&pixel_x_bits[30:23] || &pixel_y_bits[30:23] || octave[7])
          post(kot_pkg::ST_INVALID, -1, 1'b1);
        else if (idx >= 0) post(kot_pkg::ST_DUPLICATE, -1, 1'b1);
        else if (table_q.size() >= CAPACITY) post(kot_pkg::ST_FULL, -1, 1'b1);
        else begin
          r.kf = kf_id; r.mp = mp_id; r.px = pixel_x_bits;
          r.py = pixel_y_bits; r.oct = octave; r.outl = outlier_flag;
          table_q.insert(table_q.size(), r);
          post(kot_pkg::ST_OK, -1, 1'b1);
        end
      end
      kot_pkg::REQ_ERASE: begin
        if (idx >= 0) table_q.delete(idx);
        post(idx >= 0 ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, -1, 1'b1);
      end
      kot_pkg::REQ_SET_OUTLIER: begin
        if (idx >= 0) table_q[idx].outl = outlier_flag;
        post(idx >= 0 ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, -1, 1'b1);
      end
      kot_pkg::REQ_CONTAINS: post(idx >= 0 ? kot_pkg::ST_OK : kot_pkg::ST_NOT_FOUND, idx, 1'b1);
      kot_pkg::REQ_BY_KEYFRAME, kot_pkg::REQ_BY_MAP_POINT, kot_pkg::REQ_LIST_ALL: begin
        foreach (table_q[i])
          if (req_type == kot_pkg::REQ_LIST_ALL
              || (req_type == kot_pkg::REQ_BY_KEYFRAME && table_q[i].kf == kf_id)
              || (req_type == kot_pkg::REQ_BY_MAP_POINT && table_q[i].mp == mp_id))
            hits.insert(hits.size(), i);
        if (hits.size() == 0) post(kot_pkg::ST_NOT_FOUND, -1, 1'b1);
        foreach (hits[j]) post(kot_pkg::ST_OK, hits[j], j == hits.size() - 1);
      end
      default: post(kot_pkg::ST_INVALID, -1, 1'b1);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    kot_pkg::res_t w;
    if (rst) begin
      fail_count = 0;
      pending = 0;
    end else begin
      if (push && !full) apply_request();
      if (pop && !empty) begin
        if (answers.size() == 0) report("unexpected word", '0, '0);
        else begin
          w = answers.pop_front();
          if (status !== w.status) report("status", 32'(status), 32'(w.status));
          if (match_valid !== w.match_valid)
            report("match_valid", 32'(match_valid), 32'(w.match_valid));
          if (out_keyframe_id !== w.kf_id) report("keyframe", out_keyframe_id, w.kf_id);
          if (out_map_point_id !== w.mp_id) report("map_point", out_map_point_id, w.mp_id);
          if (out_pixel_x_bits !== w.pixel_x_bits)
            report("pixel_x", out_pixel_x_bits, w.pixel_x_bits);
          if (out_pixel_y_bits !== w.pixel_y_bits)
            report("pixel_y", out_pixel_y_bits, w.pixel_y_bits);
          if (out_octave !== w.octave) report("octave", 32'(out_octave), 32'(w.octave));
          if (out_outlier !== w.outlier) report("outlier", 32'(out_outlier), 32'(w.outlier));
          if (last !== w.last) report("last", 32'(last), 32'(w.last));
          if (entry_count !== w.entry_count)
            report("entry_count", 32'(entry_count), 32'(w.entry_count));
        end
      end
      pending = answers.size();
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic [2:0] req_type = '0;
  logic [31:0] kf_id = '0, mp_id = '0, pixel_x_bits = '0, pixel_y_bits = '0;
  logic [7:0] octave = '0;
  logic outlier_flag = 0;
  wire logic full, empty, match_valid, out_outlier, last;
  wire logic [2:0] status;
  wire logic [31:0] out_keyframe_id, out_map_point_id, out_pixel_x_bits, out_pixel_y_bits;
  wire logic [7:0] out_octave;
  wire logic [6:0] entry_count;
  int fail_count, pending;
  int gap_left = 0, stall_mode = 0;

  always #5 clk = ~clk;

  keyed_observation_table dut (.*);
  kot_checker #(.CAPACITY(kot_pkg::CAPACITY_DEF)) checker_i (.*);

  always @(posedge clk) begin
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 9) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send(logic [2:0] rt, logic [31:0] kf, logic [31:0] mp,
                      logic [31:0] px, logic [31:0] py, logic [7:0] oc, logic ol);
    if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rt; kf_id <= kf; mp_id <= mp;
    pixel_x_bits <= px; pixel_y_bits <= py; octave <= oc; outlier_flag <= ol;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [31:0] finite_bits();
    logic [31:0] b;
    b = $urandom;
    if (&b[30:23]) b[23] = 1'b0;
    return b;
  endfunction

  task automatic add_random(logic [31:0] kf, logic [31:0] mp);
    send(kot_pkg::REQ_ADD, kf, mp, finite_bits(), finite_bits(), 8'($urandom_range(0, 127)),
         1'($urandom));
  endtask

  initial begin
    logic [31:0] k, m;
    int op;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(kot_pkg::REQ_LIST_ALL, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_ERASE, 1, 1, 0, 0, 0, 0);
    send(kot_pkg::REQ_CONTAINS, 1, 1, 0, 0, 0, 0);
    send(kot_pkg::REQ_ADD, 0, 0, 32'h7F800000, 0, 0, 0);
    send(kot_pkg::REQ_ADD, 0, 0, 0, 32'hFFC00000, 0, 0);
    send(kot_pkg::REQ_ADD, 0, 0, 0, 0, 8'h80, 0);
    send(kot_pkg::REQ_ADD, 0, 0, 32'h7F7FFFFF, 32'hFF7FFFFF, 8'd127, 1);
    send(kot_pkg::REQ_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h00000001, 0, 0);
    send(kot_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_SET_OUTLIER, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1);
    send(kot_pkg::REQ_SET_OUTLIER, 5, 5, 0, 0, 0, 1);
    send(kot_pkg::REQ_CONTAINS, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
    send(kot_pkg::REQ_BY_KEYFRAME, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_BY_MAP_POINT, 0, 32'hFFFFFFFF, 0, 0, 0, 0);
    send(kot_pkg::REQ_BY_MAP_POINT, 0, 7, 0, 0, 0, 0);
    send(kot_pkg::REQ_UNUSED, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_LIST_ALL, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_ERASE, 0, 0, 0, 0, 0, 0);
    send(kot_pkg::REQ_LIST_ALL, 0, 0, 0, 0, 0, 0);
    // fill past capacity to hit the full refusal
    for (int i = 0; i < 66; i++) add_random(i % 8, i);
    send(kot_pkg::REQ_LIST_ALL, 0, 0, 0, 0, 0, 0);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 385; i++) begin
      if (gap_left > 0) gap_left--;
      else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
      op = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
      m = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 70);
      if (op < 35) add_random(k, m);
      else if (op < 40)
        send(kot_pkg::REQ_ADD, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 55)
        send(kot_pkg::REQ_ERASE, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 63)
        send(kot_pkg::REQ_SET_OUTLIER, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 73)
        send(kot_pkg::REQ_CONTAINS, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 83)
        send(kot_pkg::REQ_BY_KEYFRAME, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 92)
        send(kot_pkg::REQ_BY_MAP_POINT, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else if (op < 98)
        send(kot_pkg::REQ_LIST_ALL, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
      else send(kot_pkg::REQ_UNUSED, k, m, $urandom, $urandom, 8'($urandom), 1'($urandom));
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

@@ keyed_observation_table.f @@
src/kot_pkg.sv
src/kot_front.sv
src/kot_back.sv
src/keyed_observation_table.sv
tb/kot_checker.sv
tb/tb_top.sv
